// ===== hw/rtl/kpcm_pkg.sv =====
package kpcm_pkg;

  localparam int POOL_BYTES_DEF = 64;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_MIX   = 2'd1,
    ACT_APPLY = 2'd2,
    ACT_NOP   = 2'd3
  } act_t;

  // control fields carried from the front stage into the pool stage
  typedef struct packed {
    logic       vld;
    act_t       act;
    logic       pass_ok;
    logic       trailing;
    logic [1:0] byte_sel;
  } ctl_t;

  // one byte of reflected crc-32, no final inversion
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/kpcm_front.sv =====
module kpcm_front #(
  parameter int POOL_BYTES = kpcm_pkg::POOL_BYTES_DEF,
  localparam int NW = POOL_BYTES / 4,
  localparam int WW = $clog2(NW)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [1:0]          in_action,
  input  logic [7:0]          in_data_byte,
  input  logic                in_first_of_file,
  input  logic [5:0]          in_position,
  input  logic [6:0]          in_pass_length,
  output kpcm_pkg::ctl_t      ctl,
  output logic [7:0]          data,
  output logic [31:0]         crc,
  output logic [WW-1:0]       row
);
  import kpcm_pkg::*;

  // index width wide enough for the position and for the pool size itself
  localparam int IXW = ($clog2(POOL_BYTES + 1) > 7) ? $clog2(POOL_BYTES + 1) : 7;

  logic          a_vld_r;
  act_t          a_act_r;
  logic [7:0]    a_data_r;
  logic          a_first_r;
  logic [5:0]    a_pos_r;
  logic [6:0]    a_len_r;

  logic [31:0]   crc_r, crc_nxt;
  logic [WW-1:0] widx_r, widx_nxt;

  logic [31:0]   cur_crc;
  logic [WW-1:0] cur_w;
  logic [IXW-1:0] idx;
  logic [IXW-1:0] row_full;
  logic          trailing;
  logic [WW-1:0] rd_row;
  logic          is_mix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      crc_r   <= CRC_INIT;
      widx_r  <= '0;
    end else if (en) begin
      a_vld_r <= in_valid;
      if (is_mix) begin
        crc_r  <= crc_nxt;
        widx_r <= widx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      a_act_r   <= act_t'(in_action);
      a_data_r  <= in_data_byte;
      a_first_r <= in_first_of_file;
      a_pos_r   <= in_position;
      a_len_r   <= in_pass_length;
    end
  end

  assign is_mix  = a_vld_r && (a_act_r == ACT_MIX);
  assign cur_crc = a_first_r ? CRC_INIT : crc_r;
  assign cur_w   = a_first_r ? '0 : widx_r;
  assign crc_nxt = crc_byte(cur_crc, a_data_r);

  always_comb begin
    if (cur_w == WW'(NW - 1)) begin
      widx_nxt = '0;
    end else begin
      widx_nxt = cur_w + WW'(1);
    end
  end

  // position mod pool size: position stays below four pool sizes
  always_comb begin
    idx = IXW'(a_pos_r);
    for (int k = 0; k < 3; k++) begin
      if (idx >= IXW'(POOL_BYTES)) begin
        idx = idx - IXW'(POOL_BYTES);
      end
    end
  end

  assign row_full = idx >> 2;
  assign trailing = (row_full >= IXW'(NW));
  assign rd_row   = trailing ? '0 : row_full[WW-1:0];

  assign ctl.vld      = a_vld_r;
  assign ctl.act      = a_act_r;
  assign ctl.pass_ok  = ({1'b0, a_pos_r} < a_len_r);
  assign ctl.trailing = trailing;
  assign ctl.byte_sel = idx[1:0];
  assign data         = a_data_r;
  assign crc          = crc_nxt;
  assign row          = (a_act_r == ACT_APPLY) ? rd_row : cur_w;

endmodule

// ===== hw/rtl/kpcm_pool.sv =====
module kpcm_pool #(
  parameter int POOL_BYTES = kpcm_pkg::POOL_BYTES_DEF,
  localparam int NW = POOL_BYTES / 4,
  localparam int WW = $clog2(NW)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  kpcm_pkg::ctl_t ctl,
  input  logic [7:0]     data,
  input  logic [31:0]    crc,
  input  logic [WW-1:0]  row,
  output logic           res_valid,
  output logic [7:0]     res_byte
);
  import kpcm_pkg::*;

  // pool word row holds byte 4*row+k at bits [8k+7:8k]
  logic [31:0]   mem [NW];
  logic [NW-1:0] row_vld_r;

  logic          b_vld_r;
  ctl_t          b_ctl_r;
  logic [7:0]    b_data_r;
  logic [31:0]   b_crc_r;
  logic [WW-1:0] b_row_r;
  logic [31:0]   rdata_r;
  logic          fwd_hit_r;
  logic [31:0]   fwd_word_r;

  logic [31:0]   old_word;
  logic [31:0]   new_word;
  logic          b_mix;
  logic          b_clear;
  logic [7:0]    pool_b;
  logic [7:0]    pass_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r   <= 1'b0;
      fwd_hit_r <= 1'b0;
      row_vld_r <= '0;
    end else if (en) begin
      b_vld_r   <= ctl.vld;
      fwd_hit_r <= b_mix && ctl.vld && (row == b_row_r);
      if (b_clear) begin
        row_vld_r <= '0;
      end else if (b_mix) begin
        row_vld_r[b_row_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_ctl_r    <= ctl;
      b_data_r   <= data;
      b_crc_r    <= crc;
      b_row_r    <= row;
      rdata_r    <= mem[row];
      fwd_word_r <= new_word;
      if (b_mix) begin
        mem[b_row_r] <= new_word;
      end
    end
  end

  assign b_mix   = b_vld_r && (b_ctl_r.act == ACT_MIX);
  assign b_clear = b_vld_r && (b_ctl_r.act == ACT_CLEAR);

  // word just written by the previous transaction bypasses the stale read
  always_comb begin
    if (fwd_hit_r) begin
      old_word = fwd_word_r;
    end else if (row_vld_r[b_row_r]) begin
      old_word = rdata_r;
    end else begin
      old_word = '0;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      new_word[8*k +: 8] = old_word[8*k +: 8] + b_crc_r[(31 - 8*k) -: 8];
    end
  end

  assign pool_b    = b_ctl_r.trailing ? 8'd0 : old_word[8*b_ctl_r.byte_sel +: 8];
  assign pass_b    = b_ctl_r.pass_ok ? b_data_r : 8'd0;
  assign res_byte  = pass_b + pool_b;
  assign res_valid = b_vld_r && (b_ctl_r.act == ACT_APPLY);

endmodule

// ===== hw/rtl/keyfile_pool_crc_mixer.sv =====
// keyfile pool mixer: crc-32 driven mixing of keyfile bytes into a byte pool
// input channel (in_valid / in_stall) carries one action per transaction:
//   clear zeroes the pool, mix feeds one keyfile byte (first_of_file restarts
//   the crc at all ones and the pool word at zero), apply adds a pool byte to
//   a password byte and is the only action that yields a result transaction
// result channel (out_valid / out_stall) carries out_byte
// an apply result passes the input register, which loads at acceptance, then the
//   registered pool read and the output register
// throughput: one transaction per cycle unless a result is held under out_stall;
//   back-to-back mixes into the same pool word are served by a one-entry bypass around the pool memory
// reset: rst_n low clears the pipeline, sets the crc to all ones and the word
//   index to zero; per-word valid bits make the whole pool read as zero at
//   once, so neither reset nor the clear action needs a clearing pass
// stall: while a result waits under out_stall the whole pipeline holds and
//   in_stall is raised; otherwise a new transaction is taken every cycle
module keyfile_pool_crc_mixer #(
  parameter int POOL_BYTES = kpcm_pkg::POOL_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_of_file,
  input  logic [5:0] in_position,
  input  logic [6:0] in_pass_length,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte
);
  import kpcm_pkg::*;

  localparam int NW = POOL_BYTES / 4;
  localparam int WW = $clog2(NW);

  // pipeline advance: only a result held under stall blocks it
  logic          en;
  ctl_t          ctl;
  logic [7:0]    f_data;
  logic [31:0]   f_crc;
  logic [WW-1:0] f_row;
  logic          res_valid;
  logic [7:0]    res_byte;

  logic          out_valid_r;
  logic [7:0]    out_byte_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // front stage: input register, crc update, word index and pool address
  kpcm_front #(
    .POOL_BYTES (POOL_BYTES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (en),
    .in_valid         (in_valid),
    .in_action        (in_action),
    .in_data_byte     (in_data_byte),
    .in_first_of_file (in_first_of_file),
    .in_position      (in_position),
    .in_pass_length   (in_pass_length),
    .ctl              (ctl),
    .data             (f_data),
    .crc              (f_crc),
    .row              (f_row)
  );

  // pool stage: word memory, valid bits, read-modify-write and apply sum
  kpcm_pool #(
    .POOL_BYTES (POOL_BYTES)
  ) u_pool (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl       (ctl),
    .data      (f_data),
    .crc       (f_crc),
    .row       (f_row),
    .res_valid (res_valid),
    .res_byte  (res_byte)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_byte_r <= res_byte;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

`ifndef ASSERT_OFF
  // an accepted apply reaches the output while the pipeline keeps advancing
  a_apply_result : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_action == ACT_APPLY)) ##1 !in_stall ##1 !in_stall
    |=> out_valid)
    else $error("apply transaction produced no result");

  // any other action leaves the output slot empty
  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_action != ACT_APPLY)) ##1 !in_stall ##1 !in_stall
    |=> !out_valid)
    else $error("result produced for non-apply transaction");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule
